@@ hdl/acsv_pkg.sv @@
// shared types, constants and character tests for the csi sequence validator
package acsv_pkg;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned VAL_W   = 16;

  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_B    = 8'h42;
  localparam logic [7:0] CH_UP_C    = 8'h43;
  localparam logic [7:0] CH_UP_D    = 8'h44;
  localparam logic [7:0] CH_UP_H    = 8'h48;
  localparam logic [7:0] CH_UP_J    = 8'h4A;
  localparam logic [7:0] CH_UP_K    = 8'h4B;
  localparam logic [7:0] CH_UP_P    = 8'h50;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_LO_M    = 8'h6D;
  localparam logic [7:0] CH_LO_N    = 8'h6E;
  localparam logic [7:0] CH_LO_S    = 8'h73;
  localparam logic [7:0] CH_LO_U    = 8'h75;
  localparam logic [7:0] CH_LO_Z    = 8'h7A;

  // atoi-style field reader phases
  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_STOP   = 2'd3
  } field_phase_t;

  typedef struct packed {
    logic clear;   // field ends or sequence restarts
    logic step;    // parameter byte goes into the field
  } field_ctrl_t;

  typedef struct packed {
    logic nonempty;
    logic erase_ok;
    logic sgr_ok;
  } field_status_t;

  function automatic logic is_final_byte(input logic [7:0] b);
    return (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z) || b == CH_AT;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic sgr_value_ok(input logic [VAL_W-1:0] v);
    return v == VAL_W'(0) || v == VAL_W'(1) || v == VAL_W'(5) || v == VAL_W'(7)
        || v == VAL_W'(8) || (v >= VAL_W'(30) && v <= VAL_W'(37))
        || (v >= VAL_W'(40) && v <= VAL_W'(47));
  endfunction

endpackage

@@ hdl/acsv_if.sv @@
// valid/ready channel interfaces for the text byte input and the result output
interface acsv_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface acsv_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] final_byte;
  logic       seq_valid;

  modport source (output valid, output final_byte, output seq_valid, input ready);
  modport sink   (input valid, input final_byte, input seq_valid, output ready);
endinterface

@@ hdl/acsv_field.sv @@
// atoi-style reader for one parameter field, with its range checks
module acsv_field (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             data,
  input  acsv_pkg::field_ctrl_t  ctrl,
  output acsv_pkg::field_status_t status
);
  import acsv_pkg::*;

  field_phase_t      phase, phase_next;
  logic              negative, negative_next;
  logic [VAL_W-1:0]  value, value_next;
  logic              nonempty, nonempty_next;

  logic              digit;
  logic [3:0]        digit_val;
  logic [VAL_W+3:0]  acc;
  logic [VAL_W-1:0]  acc_sat;

  assign digit     = is_digit(data);
  assign digit_val = 4'(data - CH_ZERO);
  // value * 10 + digit, saturating at the field width
  assign acc       = ({4'b0, value} << 3) + ({4'b0, value} << 1) + (VAL_W+4)'(digit_val);
  assign acc_sat   = (|acc[VAL_W+3:VAL_W]) ? {VAL_W{1'b1}} : acc[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LEAD;
      negative <= 1'b0;
      value    <= '0;
      nonempty <= 1'b0;
    end else begin
      phase    <= phase_next;
      negative <= negative_next;
      value    <= value_next;
      nonempty <= nonempty_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    value_next    = value;
    nonempty_next = nonempty;
    if (ctrl.clear) begin
      phase_next    = PH_LEAD;
      negative_next = 1'b0;
      value_next    = '0;
      nonempty_next = 1'b0;
    end else if (ctrl.step) begin
      nonempty_next = 1'b1;
      unique case (phase)
        PH_LEAD: begin
          if (is_space(data)) begin
            phase_next = PH_LEAD;
          end else if (data == CH_PLUS || data == CH_MINUS) begin
            negative_next = (data == CH_MINUS);
            phase_next    = PH_SIGN;
          end else if (digit) begin
            value_next = acc_sat;
            phase_next = PH_DIGITS;
          end else begin
            phase_next = PH_STOP;
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (digit) begin
            value_next = acc_sat;
            phase_next = PH_DIGITS;
          end else begin
            phase_next = PH_STOP;
          end
        end
        PH_STOP: phase_next = PH_STOP;
        default: phase_next = PH_LEAD;
      endcase
    end
  end

  // "-0" counts as zero, any other negative value fails both checks
  logic neg_bad;
  assign neg_bad         = negative && (value != '0);
  assign status.nonempty = nonempty;
  assign status.erase_ok = !neg_bad && (value <= VAL_W'(2));
  assign status.sgr_ok   = !neg_bad && sgr_value_ok(value);

endmodule

@@ hdl/ansi_csi_sequence_validator.sv @@
// top level: checks ansi csi escape sequences in a byte stream
//
// Usage:
//   text   - sink channel, one byte of the stream per beat (in_byte)
//   result - source channel, one beat per completed sequence: the letter or
//            '@' that ended it (final_byte) and whether it is accepted
//            (seq_valid)
// Throughput is one byte per cycle while result is not stalled. A byte is
// taken into an input register and processed there against the sequence
// state once the result register can advance; a final byte loads the result
// register when it is processed, and the result beat is offered from there
// until it is taken. Bytes that end no sequence give no result beat.
// When result is stalled the result register holds; the input register may
// still hold one byte, and text.ready falls only when a byte waits behind a
// result that has not been taken. The synchronous reset leaves no sequence
// open and both registers empty, but does not clear their data. Sequences longer
// than MAX_LEN bytes, final byte included, are reported invalid.
module ansi_csi_sequence_validator (
  input  logic          clk,
  input  logic          rst,
  acsv_text_if.sink     text,
  acsv_result_if.source result
);
  import acsv_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_adv;
  logic       proc;

  // sequence state
  logic             in_sequence;
  logic             bracket_seen;
  logic [LEN_W-1:0] seq_length;
  logic             first_field_done;
  logic             first_field_ok_erase;
  logic             any_field_seen;
  logic             all_fields_ok;

  // result register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_ok;

  field_ctrl_t   fctrl;
  field_status_t fstat;

  logic b_esc, b_final, b_semi, in_params, fin, ok;
  logic first_ok_eff, any_eff, all_eff, no_params, overlong;

  assign s1_adv     = !out_valid || result.ready;
  assign text.ready = !s1_valid || s1_adv;
  assign proc       = s1_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_byte <= text.in_byte;
    end
  end

  assign b_esc     = (s1_byte == CH_ESC);
  assign b_final   = is_final_byte(s1_byte);
  assign b_semi    = (s1_byte == CH_SEMI);
  assign in_params = proc && !b_esc && in_sequence && bracket_seen;
  assign fin       = in_params && b_final;

  assign fctrl.clear = proc && (b_esc || (in_params && (b_semi || b_final)));
  assign fctrl.step  = in_params && !b_final && !b_semi;

  acsv_field u_field (
    .clk    (clk),
    .rst    (rst),
    .data   (s1_byte),
    .ctrl   (fctrl),
    .status (fstat)
  );

  // effect of closing the current field, seen by the final byte
  assign first_ok_eff = first_field_done ? first_field_ok_erase : fstat.erase_ok;
  assign any_eff      = any_field_seen || fstat.nonempty;
  assign all_eff      = all_fields_ok && (!fstat.nonempty || fstat.sgr_ok);
  assign no_params    = (seq_length == LEN_W'(2));
  assign overlong     = (seq_length >= LEN_W'(MAX_LEN));

  always_comb begin
    unique case (s1_byte)
      CH_LO_S, CH_LO_U: ok = no_params;
      CH_UP_P, CH_AT, CH_UP_A, CH_UP_B, CH_UP_C, CH_UP_D,
      CH_UP_H, CH_LO_F, CH_LO_N, CH_UP_K: ok = 1'b1;
      CH_UP_J: ok = first_ok_eff;
      CH_LO_M: ok = no_params || (any_eff && all_eff);
      default: ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sequence          <= 1'b0;
      bracket_seen         <= 1'b0;
      seq_length           <= '0;
      first_field_done     <= 1'b0;
      first_field_ok_erase <= 1'b0;
      any_field_seen       <= 1'b0;
      all_fields_ok        <= 1'b1;
    end else if (proc) begin
      if (b_esc || fin) begin
        in_sequence          <= b_esc;
        bracket_seen         <= 1'b0;
        seq_length           <= b_esc ? LEN_W'(1) : '0;
        first_field_done     <= 1'b0;
        first_field_ok_erase <= 1'b0;
        any_field_seen       <= 1'b0;
        all_fields_ok        <= 1'b1;
      end else if (in_sequence && !bracket_seen) begin
        if (s1_byte == CH_LBRACK) begin
          bracket_seen <= 1'b1;
          seq_length   <= LEN_W'(2);
        end
      end else if (in_params) begin
        if (seq_length < LEN_W'(MAX_LEN)) begin
          seq_length <= seq_length + LEN_W'(1);
        end
        if (b_semi) begin
          if (!first_field_done) begin
            first_field_ok_erase <= fstat.erase_ok;
            first_field_done     <= 1'b1;
          end
          any_field_seen <= any_eff;
          all_fields_ok  <= all_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_byte <= s1_byte;
      out_ok   <= ok && !overlong;
    end
  end

  assign result.valid      = out_valid;
  assign result.final_byte = out_byte;
  assign result.seq_valid  = out_ok;

  a_final_letter: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_final_byte(out_byte))
    else $error("result beat without a final byte");

  a_bracket_in_seq: assert property (@(posedge clk) disable iff (rst)
    bracket_seen |-> (in_sequence && seq_length >= LEN_W'(2)))
    else $error("bracket state outside a sequence");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    seq_length <= LEN_W'(MAX_LEN))
    else $error("sequence length past its bound");

  a_close_seq: assert property (@(posedge clk) disable iff (rst)
    fin |=> (!in_sequence && out_valid))
    else $error("final byte did not close the sequence");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_byte)))
    else $error("waiting byte lost during a result stall");

endmodule
